FILE: hw/rtl/k_closest_point_select_assert.svh
// Assertion shorthands shared by the block's modules.
// Both expect the clock i_clk and the active-low reset i_rst_n in scope.
`ifndef K_CLOSEST_POINT_SELECT_ASSERT_SVH
`define K_CLOSEST_POINT_SELECT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KCPS_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KCPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/kcps_pkg.sv
`timescale 1ns / 1ps

package kcps_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_BITS_DEF  = 20;
    localparam int ID_W            = 16;
    localparam int MAXT_W          = 7;
    localparam int RESULT_CAP      = 64;
    localparam logic [MAXT_W-1:0] MAXT_RESET = 7'd1;

    typedef enum logic [1:0] {
        CFG_MAX_TARGETS = 2'd0,
        CFG_ORIGIN_X    = 2'd1,
        CFG_ORIGIN_Y    = 2'd2,
        CFG_ORIGIN_Z    = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_LIST_RD,
        S_LIST_OUT,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;      // write the accepted point, or flag it as dropped
        logic clear;      // end of run: empty the set
        logic rd_list;    // read the entry at the result counter
        logic out_list;   // place the read entry's id in the output register
        logic scan_init;  // start a new pass over the store
        logic scan_rd;    // read the next entry into the distance pipeline
        logic out_best;   // place the pass winner in the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic list_mode;    // whole set fits, ids go out in load order
        logic target_zero;  // nothing to emit for this run
        logic last_result;  // the next result closes the run
        logic scan_last;    // the entry being read is the last stored one
        logic pipe_busy;    // distance pipeline still holds entries
        logic out_free;     // output register can take a result this cycle
    } t_dp_status;

endpackage

FILE: hw/rtl/k_closest_point_select.sv
`timescale 1ns / 1ps
// Channel   Direction  Contents
// s_*       in         tdata: point_id, pos_x, pos_y, pos_z; tlast: last_point
// m_*       out        tdata: target_id; tlast: last_target; tuser: overflow
// cfg_*     in         register index and write data, always ready
//
// Points load at one per cycle. Once the last point is in, a run of results
// follows: when the whole set is returned, each id is read in load order
// through the store's registered read port; otherwise each result takes one
// full pass over the store plus the four-stage distance pipeline. No input is
// taken during a run. Reset is synchronous and needs no clearing pass. A
// stalled output holds the run until the result is taken.

module k_closest_point_select import kcps_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int TDW = ((ID_W + 3 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // point_id, pos_x, pos_y, pos_z from bit 0 up, zero fill above
    input  logic [TDW-1:0]        i_s_tdata,
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // target_id
    output logic [ID_W-1:0]       o_m_tdata,
    output logic                  o_m_tlast,
    // overflow
    output logic [0:0]            o_m_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [COORD_BITS-1:0] i_cfg_data
);

    localparam int CB = COORD_BITS;

    t_dp_cmd    w_cmd;
    t_dp_status w_st;
    logic       w_overflow;

    assign o_cfg_ready = 1'b1;

    kcps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    kcps_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_point_id    (i_s_tdata[ID_W-1:0]),
        .i_pos_x       (i_s_tdata[ID_W +: CB]),
        .i_pos_y       (i_s_tdata[ID_W + CB +: CB]),
        .i_pos_z       (i_s_tdata[ID_W + 2 * CB +: CB]),
        .i_cmd         (w_cmd),
        .o_st          (w_st),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_target_id   (o_m_tdata),
        .o_last_target (o_m_tlast),
        .o_overflow    (w_overflow)
    );

    assign o_m_tuser = w_overflow;

endmodule

FILE: hw/rtl/kcps_dp.sv
`timescale 1ns / 1ps
`include "k_closest_point_select_assert.svh"

module kcps_dp import kcps_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [1:0]                   i_cfg_index,
    input  logic [COORD_BITS-1:0]        i_cfg_data,
    input  logic [ID_W-1:0]              i_point_id,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  t_dp_cmd                      i_cmd,
    output t_dp_status                   o_st,
    input  logic                         i_m_tready,
    output logic                         o_m_tvalid,
    output logic [ID_W-1:0]              o_target_id,
    output logic                         o_last_target,
    output logic                         o_overflow
);

    localparam int CB = COORD_BITS;
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int EW = ID_W + 3 * CB;
    localparam int DW = 2 * CB + 2;

    // Configuration registers.
    logic [MAXT_W-1:0]    r_max_targets;
    logic [CB-1:0]        r_org_x, r_org_y, r_org_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_targets <= MAXT_RESET;
            r_org_x       <= '0;
            r_org_y       <= '0;
            r_org_z       <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_TARGETS: r_max_targets <= i_cfg_data[MAXT_W-1:0];
                CFG_ORIGIN_X:    r_org_x <= i_cfg_data;
                CFG_ORIGIN_Y:    r_org_y <= i_cfg_data;
                CFG_ORIGIN_Z:    r_org_z <= i_cfg_data;
                default:         r_max_targets <= r_max_targets;
            endcase
        end
    end

    // Set bookkeeping.
    logic [CW-1:0]     r_count;
    logic              r_dropped;
    logic [MAXT_W-1:0] r_n;
    logic [CW-1:0]     r_idx;
    logic              w_full;

    assign w_full = (r_count == CW'(MAX_POINTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_n       <= '0;
            r_idx     <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_count   <= '0;
                r_dropped <= 1'b0;
            end else if (i_cmd.store) begin
                if (w_full) begin
                    r_dropped <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.clear) begin
                r_n <= '0;
            end else if (i_cmd.out_list || i_cmd.out_best) begin
                r_n <= r_n + MAXT_W'(1);
            end
            if (i_cmd.scan_init) begin
                r_idx <= '0;
            end else if (i_cmd.scan_rd) begin
                r_idx <= r_idx + CW'(1);
            end
        end
    end

    // Point store: one write port for loading, one registered read port.
    logic [EW-1:0] r_mem [MAX_POINTS];
    logic [EW-1:0] r_rd_data;
    logic [AW-1:0] w_rd_addr;

    assign w_rd_addr = i_cmd.rd_list ? AW'(r_n) : AW'(r_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && !w_full) begin
            r_mem[AW'(r_count)] <= {i_pos_z, i_pos_y, i_pos_x, i_point_id};
        end
        if (i_cmd.rd_list || i_cmd.scan_rd) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Distance pipeline: read, absolute differences, squares, sum, best update.
    logic          r_p0_vld, r_p1_vld, r_p2_vld, r_p3_vld;
    logic [AW-1:0] r_p0_idx, r_p1_idx, r_p2_idx, r_p3_idx;
    logic [ID_W-1:0] r_p1_id, r_p2_id, r_p3_id;
    logic [CB-1:0] r_p1_ax, r_p1_ay, r_p1_az;
    logic [2*CB-1:0] r_p2_sx, r_p2_sy, r_p2_sz;
    logic [DW-1:0] r_p3_d;

    logic [CB-1:0] w_px, w_py, w_pz;
    logic [CB:0]   w_dx, w_dy, w_dz;
    logic [CB-1:0] w_ax, w_ay, w_az;

    assign w_px = r_rd_data[ID_W +: CB];
    assign w_py = r_rd_data[ID_W + CB +: CB];
    assign w_pz = r_rd_data[ID_W + 2 * CB +: CB];

    assign w_dx = {w_px[CB-1], w_px} - {r_org_x[CB-1], r_org_x};
    assign w_dy = {w_py[CB-1], w_py} - {r_org_y[CB-1], r_org_y};
    assign w_dz = {w_pz[CB-1], w_pz} - {r_org_z[CB-1], r_org_z};

    // A coordinate difference never exceeds 2^CB - 1 in magnitude.
    assign w_ax = w_dx[CB] ? CB'(-w_dx) : w_dx[CB-1:0];
    assign w_ay = w_dy[CB] ? CB'(-w_dy) : w_dy[CB-1:0];
    assign w_az = w_dz[CB] ? CB'(-w_dz) : w_dz[CB-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_vld <= 1'b0;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
        end else begin
            r_p0_vld <= i_cmd.scan_rd;
            r_p1_vld <= r_p0_vld;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0_idx <= w_rd_addr;
        r_p1_idx <= r_p0_idx;
        r_p1_id  <= r_rd_data[ID_W-1:0];
        r_p1_ax  <= w_ax;
        r_p1_ay  <= w_ay;
        r_p1_az  <= w_az;
        r_p2_idx <= r_p1_idx;
        r_p2_id  <= r_p1_id;
        r_p2_sx  <= r_p1_ax * r_p1_ax;
        r_p2_sy  <= r_p1_ay * r_p1_ay;
        r_p2_sz  <= r_p1_az * r_p1_az;
        r_p3_idx <= r_p2_idx;
        r_p3_id  <= r_p2_id;
        r_p3_d   <= DW'(r_p2_sx) + DW'(r_p2_sy) + DW'(r_p2_sz);
    end

    // Points already emitted are exactly those ordered at or below the
    // previous winner by (distance, load index), so no per-entry mask is kept.
    logic            r_have_prev, r_have_best;
    logic [DW-1:0]   r_prev_d, r_best_d;
    logic [AW-1:0]   r_prev_idx, r_best_idx;
    logic [ID_W-1:0] r_best_id;
    logic            w_after_prev, w_better, w_upd;

    assign w_after_prev = !r_have_prev || (r_p3_d > r_prev_d) ||
                          ((r_p3_d == r_prev_d) && (r_p3_idx > r_prev_idx));
    assign w_better     = !r_have_best || (r_p3_d < r_best_d);
    assign w_upd        = r_p3_vld && w_after_prev && w_better;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_have_best <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_have_prev <= 1'b0;
            end else if (i_cmd.out_best) begin
                r_have_prev <= 1'b1;
            end
            if (i_cmd.scan_init) begin
                r_have_best <= 1'b0;
            end else if (w_upd) begin
                r_have_best <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd) begin
            r_best_d   <= r_p3_d;
            r_best_idx <= r_p3_idx;
            r_best_id  <= r_p3_id;
        end
        if (i_cmd.out_best) begin
            r_prev_d   <= r_best_d;
            r_prev_idx <= r_best_idx;
        end
    end

    // Run status.
    logic [MAXT_W-1:0] w_cnt_cap, w_maxt_cap, w_target;
    logic              w_list_mode;

    assign w_cnt_cap   = (32'(r_count) > RESULT_CAP) ? MAXT_W'(RESULT_CAP)
                                                     : MAXT_W'(r_count);
    assign w_maxt_cap  = (32'(r_max_targets) > RESULT_CAP) ? MAXT_W'(RESULT_CAP)
                                                           : r_max_targets;
    assign w_list_mode = (32'(r_count) <= 32'(r_max_targets));
    assign w_target    = w_list_mode ? w_cnt_cap : w_maxt_cap;

    // Output register.
    logic            r_out_vld, r_out_last, r_out_ovf;
    logic [ID_W-1:0] r_out_id;
    logic            w_out_free;

    assign w_out_free = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_list || i_cmd.out_best) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_list || i_cmd.out_best) begin
            r_out_id   <= i_cmd.out_list ? r_rd_data[ID_W-1:0] : r_best_id;
            r_out_last <= o_st.last_result;
            r_out_ovf  <= r_dropped;
        end
    end

    always_comb begin
        o_st.list_mode   = w_list_mode;
        o_st.target_zero = (w_target == '0);
        o_st.last_result = ((r_n + MAXT_W'(1)) == w_target);
        o_st.scan_last   = ((r_idx + CW'(1)) == r_count);
        o_st.pipe_busy   = r_p0_vld || r_p1_vld || r_p2_vld || r_p3_vld;
        o_st.out_free    = w_out_free;
    end

    assign o_m_tvalid    = r_out_vld;
    assign o_target_id   = r_out_id;
    assign o_last_target = r_out_last;
    assign o_overflow    = r_out_ovf;

    `KCPS_ASSERT(a_best_exists, i_cmd.out_best, r_have_best, "emit without a pass winner")
    `KCPS_ASSERT(a_scan_in_set, i_cmd.scan_rd, r_idx < r_count, "scan beyond loaded points")
    `KCPS_ASSERT_NEXT(a_clear_empties, i_cmd.clear,
        (r_count == '0) && !r_dropped && (r_n == '0), "set not emptied after run")

endmodule

FILE: hw/rtl/kcps_ctrl.sv
`timescale 1ns / 1ps
`include "k_closest_point_select_assert.svh"

module kcps_ctrl import kcps_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tlast,
    output logic       o_s_tready,
    input  t_dp_status i_st,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_LOAD: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.store = 1'b1;
                    if (i_s_tlast) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                if (i_st.target_zero) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_LOAD;
                end else if (i_st.list_mode) begin
                    n_state = S_LIST_RD;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_LIST_RD: begin
                o_cmd.rd_list = 1'b1;
                n_state       = S_LIST_OUT;
            end
            S_LIST_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.out_list = 1'b1;
                    if (i_st.last_result) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_LOAD;
                    end else begin
                        n_state = S_LIST_RD;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_st.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_st.pipe_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_st.out_free) begin
                    o_cmd.out_best = 1'b1;
                    if (i_st.last_result) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_LOAD;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    `KCPS_ASSERT(a_emit_after_drain, r_state == S_EMIT, !i_st.pipe_busy,
        "winner taken while distances are still in flight")

endmodule

FILE: bench/k_closest_point_select_tb.sv
`timescale 1ns / 1ps

module k_closest_point_select_tb;
    import kcps_pkg::*;

    localparam int CW            = COORD_BITS_DEF;
    localparam int TDW           = ((ID_W + 3 * CW + 7) / 8) * 8;
    localparam int CMAX          = (1 << (CW - 1)) - 1;
    localparam int CMIN          = -(1 << (CW - 1));
    localparam int RAND_ITEMS    = 185;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 400_000;

    typedef struct {
        logic [ID_W-1:0]      id;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 last;
    } t_point;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            last;
        logic            ovf;
    } t_target;

    typedef enum logic {ROW_CFG, ROW_POINT} t_row_kind;

    typedef struct {
        t_row_kind       kind;
        t_cfg_idx        reg_idx;
        logic [CW-1:0]   reg_data;
        t_point          pt;
        logic            typed;   // expected target written out in the row
        t_target         res;
    } t_dir_row;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_s_tvalid = 1'b0;
    logic            o_s_tready;
    logic [TDW-1:0]  i_s_tdata = '0;
    logic            i_s_tlast = 1'b0;
    logic            o_m_tvalid;
    logic            i_m_tready = 1'b0;
    logic [ID_W-1:0] o_m_tdata;
    logic            o_m_tlast;
    logic [0:0]      o_m_tuser;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [1:0]      i_cfg_index = '0;
    logic [CW-1:0]   i_cfg_data = '0;

    k_closest_point_select u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Shadow of the block: loaded set and register values.
    t_point               set_pts [MAX_POINTS_DEF];
    bit                   taken [MAX_POINTS_DEF];
    int                   set_count = 0;
    bit                   set_dropped = 1'b0;
    logic [MAXT_W-1:0]    max_tgt = MAXT_RESET;
    logic signed [CW-1:0] org_x = '0;
    logic signed [CW-1:0] org_y = '0;
    logic signed [CW-1:0] org_z = '0;

    t_target   picked_q [$];
    t_target   target_q [$];
    t_dir_row  dir_tab [$];
    bit        id_seen [logic [ID_W-1:0]];
    bit        calm = 1'b0;
    bit        run_outstanding = 1'b0;
    int        near_pct = 0;
    int        mismatch_cnt = 0;
    int        cycle_cnt = 0;
    int        stall_left = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint dist_sq(input t_point p);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'(p.x) - longint'(org_x);
        dy = longint'(p.y) - longint'(org_y);
        dz = longint'(p.z) - longint'(org_z);
        return dx * dx + dy * dy + dz * dz;
    endfunction

    // Loads one point; on the closing point of a set, fills picked_q with the run.
    function automatic void take_point(input t_point p);
        int     want;
        int     best;
        longint best_d;
        longint d;
        bit     have;
        if (set_count < MAX_POINTS_DEF) begin
            set_pts[set_count] = p;
            taken[set_count] = 1'b0;
            set_count++;
        end else begin
            set_dropped = 1'b1;
        end
        if (!p.last) return;
        if (set_count <= int'(max_tgt)) begin
            for (int i = 0; i < set_count; i++)
                picked_q.push_back('{set_pts[i].id, 1'(i + 1 == set_count), set_dropped});
        end else begin
            want = (int'(max_tgt) > RESULT_CAP) ? RESULT_CAP : int'(max_tgt);
            for (int k = 0; k < want; k++) begin
                have = 1'b0;
                best = 0;
                best_d = 0;
                for (int i = 0; i < set_count; i++) begin
                    if (!taken[i]) begin
                        d = dist_sq(set_pts[i]);
                        // Strictly smaller only, so the earliest point keeps a tie.
                        if (!have || d < best_d) begin
                            have = 1'b1;
                            best = i;
                            best_d = d;
                        end
                    end
                end
                taken[best] = 1'b1;
                picked_q.push_back('{set_pts[best].id, 1'(k + 1 == want), set_dropped});
            end
        end
        set_count = 0;
        set_dropped = 1'b0;
        foreach (taken[i]) taken[i] = 1'b0;
    endfunction

    task automatic send_point(input t_point p, input bit use_typed, input t_target typed_res);
        int gap;
        gap = pick_gap();
        i_cfg_valid <= 1'b0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= TDW'({p.z, p.y, p.x, p.id});
        i_s_tlast  <= p.last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        run_outstanding = 1'b1;
        take_point(p);
        if (use_typed) begin
            target_q.push_back(typed_res);
        end else begin
            foreach (picked_q[i]) target_q.push_back(picked_q[i]);
        end
        picked_q.delete();
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CW-1:0] data);
        int gap;
        // Registers change only once the previous set has fully drained.
        if (run_outstanding) begin
            i_s_tvalid <= 1'b0;
            while (target_q.size() != 0) @(posedge i_clk);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            run_outstanding = 1'b0;
        end
        gap = pick_gap();
        if (gap > 0) begin
            i_cfg_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_MAX_TARGETS: max_tgt = data[MAXT_W-1:0];
            CFG_ORIGIN_X:    org_x = data;
            CFG_ORIGIN_Y:    org_y = data;
            CFG_ORIGIN_Z:    org_z = data;
            default: ;
        endcase
    endtask

    function automatic logic [CW-1:0] rand_reg_value(input t_cfg_idx idx);
        logic [CW-1:0] v;
        v = $urandom;
        if (idx == CFG_MAX_TARGETS) begin
            // Bits above the count field are junk the block has to ignore.
            case ($urandom_range(0, 7))
                0:       v[MAXT_W-1:0] = 0;
                1:       v[MAXT_W-1:0] = 1;
                2:       v[MAXT_W-1:0] = 64;
                3:       v[MAXT_W-1:0] = 127;
                4:       v[MAXT_W-1:0] = $urandom_range(65, 126);
                default: v[MAXT_W-1:0] = $urandom_range(2, 12);
            endcase
        end else begin
            case ($urandom_range(0, 4))
                0:       v = CMAX;
                1:       v = CMIN;
                2:       v = '0;
                default: ;
            endcase
        end
        return v;
    endfunction

    function automatic logic signed [CW-1:0] rand_coord(input logic signed [CW-1:0] org);
        logic signed [CW-1:0] v;
        int r;
        int off;
        r = $urandom_range(0, 9);
        off = $urandom_range(0, 6);
        off = off - 3;
        v = $urandom;
        if (r < near_pct) begin
            v = org + off;
        end else if (r == 9) begin
            case ($urandom_range(0, 3))
                0:       v = CMAX;
                1:       v = CMIN;
                2:       v = '0;
                default: v = -1;
            endcase
        end
        return v;
    endfunction

    function automatic t_point rand_point(input bit last);
        t_point p;
        do p.id = $urandom_range(0, 65535); while (id_seen.exists(p.id));
        id_seen[p.id] = 1'b1;
        p.x = rand_coord(org_x);
        p.y = rand_coord(org_y);
        p.z = rand_coord(org_z);
        p.last = last;
        return p;
    endfunction

    function automatic t_dir_row cfg_row(input t_cfg_idx idx, input logic [CW-1:0] data);
        t_dir_row r;
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.reg_data = data;
        r.pt = '{default: '0};
        r.typed = 1'b0;
        r.res = '0;
        return r;
    endfunction

    function automatic t_dir_row pt_row(input logic [ID_W-1:0] id, input int x, input int y,
                                        input int z, input bit last);
        t_dir_row r;
        r.kind = ROW_POINT;
        r.reg_idx = CFG_MAX_TARGETS;
        r.reg_data = '0;
        r.typed = 1'b0;
        r.res = '0;
        r.pt.id = id;
        r.pt.x = x[CW-1:0];
        r.pt.y = y[CW-1:0];
        r.pt.z = z[CW-1:0];
        r.pt.last = last;
        return r;
    endfunction

    function automatic t_dir_row pt_row_exp(input logic [ID_W-1:0] id, input int x, input int y,
                                            input int z, input logic [ID_W-1:0] exp_id);
        t_dir_row r;
        r = pt_row(id, x, y, z, 1'b1);
        r.typed = 1'b1;
        r.res = '{exp_id, 1'b1, 1'b0};
        return r;
    endfunction

    // Output side: random stalls on tready.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_m_tready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_target want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (target_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected target transfer: id %h last %b ovf %b",
                             o_m_tdata, o_m_tlast, o_m_tuser[0]);
            end else begin
                want = target_q.pop_front();
                if (o_m_tdata !== want.id || o_m_tlast !== want.last
                        || o_m_tuser[0] !== want.ovf) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display(
                            "target mismatch: expected id %h last %b ovf %b, got %h %b %b",
                            want.id, want.last, want.ovf,
                            o_m_tdata, o_m_tlast, o_m_tuser[0]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("k_closest_point_select_tb: done, errors");
            $finish;
        end
    end

    initial begin
        t_point   p;
        t_cfg_idx idx;
        int       n_sent;
        int       set_no;
        int       set_size;

        // After reset: one target, origin at zero.
        dir_tab.push_back(pt_row_exp(16'hFFFF, 0, 0, 0, 16'hFFFF));
        // Opposite corners: the positive one is one unit nearer on every axis.
        dir_tab.push_back(pt_row(16'h0000, CMAX, CMAX, CMAX, 1'b0));
        dir_tab.push_back(pt_row_exp(16'h1234, CMIN, CMIN, CMIN, 16'h0000));
        // With zero targets the set is thrown away silently.
        dir_tab.push_back(cfg_row(CFG_MAX_TARGETS, 0));
        dir_tab.push_back(pt_row(16'h5555, 1, -1, 7, 1'b1));
        // A count above 64 returns the whole set in load order.
        dir_tab.push_back(cfg_row(CFG_MAX_TARGETS, 127));
        dir_tab.push_back(cfg_row(CFG_ORIGIN_X, CMAX));
        dir_tab.push_back(cfg_row(CFG_ORIGIN_Y, CMIN));
        dir_tab.push_back(cfg_row(CFG_ORIGIN_Z, -1));
        dir_tab.push_back(pt_row(16'h0101, CMIN, CMAX, 0, 1'b0));
        dir_tab.push_back(pt_row(16'h0202, 0, 0, 0, 1'b0));
        dir_tab.push_back(pt_row(16'h0303, CMAX, CMIN, -1, 1'b1));
        // Ties: two points on the origin, three more at distance one.
        dir_tab.push_back(cfg_row(CFG_MAX_TARGETS, 2));
        dir_tab.push_back(pt_row(16'h00AA, CMAX - 1, CMIN, -1, 1'b0));
        dir_tab.push_back(pt_row(16'h00BB, CMAX, CMIN + 1, -1, 1'b0));
        dir_tab.push_back(pt_row(16'h00CC, CMAX, CMIN, -1, 1'b0));
        dir_tab.push_back(pt_row(16'h00DD, CMAX, CMIN, 0, 1'b0));
        dir_tab.push_back(pt_row(16'h00EE, CMAX, CMIN, -1, 1'b1));
        dir_tab.push_back(cfg_row(CFG_MAX_TARGETS, 64));
        dir_tab.push_back(cfg_row(CFG_ORIGIN_X, CMIN));
        dir_tab.push_back(cfg_row(CFG_ORIGIN_Y, CMAX));
        dir_tab.push_back(cfg_row(CFG_ORIGIN_Z, 0));
        dir_tab.push_back(pt_row(16'h8001, CMAX, CMIN, CMAX, 1'b0));
        dir_tab.push_back(pt_row(16'h0F0F, 3, -3, 0, 1'b0));
        dir_tab.push_back(pt_row(16'hF0F0, CMIN, CMAX, 0, 1'b1));
        dir_tab.push_back(cfg_row(CFG_MAX_TARGETS, 3));
        dir_tab.push_back(pt_row(16'h8000, CMAX, CMIN, CMAX, 1'b0));
        dir_tab.push_back(pt_row(16'h7FFF, CMIN, CMAX, 1, 1'b0));
        dir_tab.push_back(pt_row(16'h4321, CMIN + 5, CMAX - 2, -3, 1'b0));
        dir_tab.push_back(pt_row(16'hC0DE, 0, 0, 0, 1'b1));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[r]) begin
            if (dir_tab[r].kind == ROW_CFG)
                write_reg(dir_tab[r].reg_idx, dir_tab[r].reg_data);
            else
                send_point(dir_tab[r].pt, dir_tab[r].typed, dir_tab[r].res);
        end

        n_sent = 0;
        set_no = 0;
        while (n_sent < RAND_ITEMS) begin
            if (set_no == 0 || $urandom_range(0, 9) < 6) begin
                idx = idx.first();
                do begin
                    if (set_no == 0 || $urandom_range(0, 1) == 1)
                        write_reg(idx, rand_reg_value(idx));
                    idx = idx.next();
                end while (idx != idx.first());
            end
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0:       near_pct = 0;
                1:       near_pct = 5;
                default: near_pct = 9;
            endcase
            // The first set overflows the store, the second fills it exactly.
            if (set_no == 0)
                set_size = MAX_POINTS_DEF + 2;
            else if (set_no == 1)
                set_size = MAX_POINTS_DEF;
            else if ($urandom_range(0, 11) == 0)
                set_size = $urandom_range(MAX_POINTS_DEF - 4, MAX_POINTS_DEF + 4);
            else
                set_size = $urandom_range(1, 10);
            id_seen.delete();
            for (int k = 0; k < set_size; k++) begin
                p = rand_point(k == set_size - 1);
                send_point(p, 1'b0, '0);
            end
            n_sent += set_size;
            set_no++;
        end

        i_s_tvalid <= 1'b0;
        while (target_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("k_closest_point_select_tb: done, clean");
        end else begin
            $display("k_closest_point_select_tb: done, errors");
        end
        $finish;
    end

endmodule
